@@ design/nc3f_pkg.sv @@
// Shared types and constants of the normalized 3x3 convolution filter.
// No dependencies; used by every module of the block.
package nc3f_pkg;

	// Default frame size limits.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS         = 3'd5;

	// Register reset values.
	localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;
	localparam logic [23:0] RST_KERNEL_TOP   = 24'h010201;
	localparam logic [23:0] RST_KERNEL_MID   = 24'h020402;
	localparam logic [23:0] RST_KERNEL_BOT   = 24'h010201;
	localparam logic [8:0]  RST_BIAS         = 9'd0;

	// Weighted sum fits 21 signed bits, weight sum 13 signed bits.
	localparam int SUM_W  = 21;
	localparam int WSUM_W = 13;

	localparam int PIX_MAX = 255;

	// Request to the divider.
	typedef struct packed {
		logic                     start;
		logic signed [SUM_W-1:0]  dividend;
		logic signed [WSUM_W-1:0] divisor;
	} div_req_t;

	// Response of the divider.
	typedef struct packed {
		logic                    done;
		logic signed [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ design/normalized_conv3x3_filter_unit.sv @@
// Top level of the normalized 3x3 convolution filter: stream ports, registers,
// window, sequencer and multiply-accumulate. Uses nc3f_pkg, nc3f_line_mem, nc3f_divider.
//
// Channel   Direction  Content
// s_axis    in         tuser = action, tdata = pixel_in[7:0]
// m_axis    out        tdata = pixel_out[7:0], tlast = frame_end
// cfg       in         cfg_we, cfg_index, cfg_wdata (write only)
//
// A drain without a result is only accepted; a pixel without a result also passes the
// line store read. A request with a result passes acceptance, line store read, 9
// multiply-accumulate steps, the divider and the output hand-off; a zero weight sum skips the division.
// Reset clears all counters and the window; the line stores are not cleared.
// A finished result waits in the output register; the next request is taken
// meanwhile and stalls only when its own result meets a full output register.
module normalized_conv3x3_filter_unit #(
	parameter int MAX_WIDTH  = nc3f_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = nc3f_pkg::DEF_MAX_HEIGHT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // pixel_in
	input  logic                             s_axis_tuser,  // action
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [7:0]                       m_axis_tdata,  // pixel_out
	output logic                             m_axis_tlast,  // frame_end
	input  logic                             cfg_we,
	input  logic [nc3f_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nc3f_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	// Configuration registers.
	logic [10:0] width_q, height_q;
	logic [23:0] ktop_q, kmid_q, kbot_q;
	logic [8:0]  bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= nc3f_pkg::RST_IMAGE_WIDTH;
			height_q <= nc3f_pkg::RST_IMAGE_HEIGHT;
			ktop_q   <= nc3f_pkg::RST_KERNEL_TOP;
			kmid_q   <= nc3f_pkg::RST_KERNEL_MID;
			kbot_q   <= nc3f_pkg::RST_KERNEL_BOT;
			bias_q   <= nc3f_pkg::RST_BIAS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nc3f_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata[10:0];
				nc3f_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata[10:0];
				nc3f_pkg::REG_KERNEL_TOP:   ktop_q   <= cfg_wdata;
				nc3f_pkg::REG_KERNEL_MID:   kmid_q   <= cfg_wdata;
				nc3f_pkg::REG_KERNEL_BOT:   kbot_q   <= cfg_wdata;
				nc3f_pkg::REG_BIAS:         bias_q   <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// Frame size saturated to the supported range.
	logic [WW-1:0] w;
	logic [HW-1:0] h;
	always_comb begin
		if (int'(width_q) < 2)               w = WW'(2);
		else if (int'(width_q) > MAX_WIDTH)  w = WW'(MAX_WIDTH);
		else                                 w = WW'(width_q);
		if (int'(height_q) < 2)              h = HW'(2);
		else if (int'(height_q) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
		else                                 h = HW'(height_q);
	end

	logic [2:0]    state_q;
	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic          done_in_q;
	logic          emit_q, flush_q;
	logic [7:0]    bottom_q;
	logic [2:0]    rok_q, cok_q;
	logic          fend_q;
	logic [7:0]    win_q [3][3];
	logic [1:0]    r_q, c_q;
	logic signed [nc3f_pkg::SUM_W-1:0]  acc_q;
	logic signed [nc3f_pkg::WSUM_W-1:0] wacc_q;
	logic signed [nc3f_pkg::SUM_W-1:0]  quot_q;
	logic          out_valid_q;
	logic [7:0]    out_pix_q;
	logic          out_last_q;

	logic          accept;
	logic [15:0]   rd_data;
	logic          in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap, ready_now;
	logic          out_free;
	nc3f_pkg::div_req_t div_req;
	nc3f_pkg::div_rsp_t div_rsp;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Position compares against the current frame size.
	always_comb begin
		in_col_wrap  = (32'(in_col_q) + 32'd1) >= 32'(w);
		in_row_wrap  = (32'(in_row_q) + 32'd1) >= 32'(h);
		out_col_wrap = (32'(out_col_q) + 32'd1) >= 32'(w);
		out_row_wrap = (32'(out_row_q) + 32'd1) >= 32'(h);
		ready_now    = (32'(in_row_q) >= 32'd2) ||
			(in_row_q == RW'(1) && in_col_q != '0);
	end

	nc3f_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_col_q),
		.rd_data (rd_data),
		.wr_en   (state_q == ST_RD),
		.wr_addr (in_col_q),
		.wr_data ({rd_data[7:0], bottom_q})
	);

	// Weight and pixel of the current accumulate step.
	logic [23:0]       krow;
	logic signed [8:0] wt;
	logic signed [17:0] prod;
	always_comb begin
		case (r_q)
			2'd0:    krow = ktop_q;
			2'd1:    krow = kmid_q;
			default: krow = kbot_q;
		endcase
		case (c_q)
			2'd0:    wt = 9'(signed'(krow[7:0]));
			2'd1:    wt = 9'(signed'(krow[15:8]));
			default: wt = 9'(signed'(krow[23:16]));
		endcase
		prod = wt * $signed({1'b0, win_q[r_q][c_q]});
	end

	// Bias and clamp of the quotient.
	logic signed [nc3f_pkg::SUM_W:0] biased;
	logic [7:0] clamped;
	always_comb begin
		biased = (nc3f_pkg::SUM_W+1)'(quot_q) + (nc3f_pkg::SUM_W+1)'($signed(bias_q));
		if (biased < 0)                                  clamped = 8'd0;
		else if (biased > (nc3f_pkg::SUM_W+1)'(nc3f_pkg::PIX_MAX)) clamped = 8'hFF;
		else                                             clamped = biased[7:0];
	end

	assign div_req.start    = (state_q == ST_MAC) && r_q == 2'd2 && c_q == 2'd2;
	assign div_req.dividend = acc_q + ((rok_q[2] && cok_q[2]) ?
		nc3f_pkg::SUM_W'(prod) : '0);
	assign div_req.divisor  = wacc_q + ((rok_q[2] && cok_q[2]) ?
		nc3f_pkg::WSUM_W'(wt) : '0);

	nc3f_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			done_in_q <= 1'b0;
			emit_q    <= 1'b0;
			flush_q   <= 1'b0;
			r_q       <= '0;
			c_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else begin
			// The output register is loaded by the last stage and cleared when taken.
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (done_in_q) begin
							flush_q <= 1'b1;
							emit_q  <= 1'b1;
							state_q <= ST_RD;
						end else if (!s_axis_tuser) begin
							flush_q <= 1'b0;
							emit_q  <= ready_now;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					// Shift the window and advance the input position.
					for (int i = 0; i < 3; i++) begin
						win_q[i][0] <= win_q[i][1];
						win_q[i][1] <= win_q[i][2];
					end
					win_q[0][2] <= rd_data[15:8];
					win_q[1][2] <= rd_data[7:0];
					win_q[2][2] <= bottom_q;
					in_col_q <= in_col_wrap ? '0 : in_col_q + 1'b1;
					if (!flush_q && in_col_wrap) begin
						if (in_row_wrap) done_in_q <= 1'b1;
						else             in_row_q  <= in_row_q + 1'b1;
					end
					if (emit_q) begin
						r_q <= '0;
						c_q <= '0;
						state_q <= ST_MAC;
						if (out_col_wrap) begin
							out_col_q <= '0;
							if (out_row_wrap) begin
								out_row_q <= '0;
								in_col_q  <= '0;
								in_row_q  <= '0;
								done_in_q <= 1'b0;
							end else begin
								out_row_q <= out_row_q + 1'b1;
							end
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MAC: begin
					if (c_q == 2'd2) begin
						c_q <= '0;
						r_q <= r_q + 1'b1;
						if (r_q == 2'd2) state_q <= ST_DIV;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request payload, neighborhood masks and datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			bottom_q <= done_in_q ? 8'd0 : s_axis_tdata;
		end
		if (state_q == ST_RD) begin
			rok_q  <= {out_row_wrap ? 1'b0 : 1'b1, 1'b1, out_row_q != '0};
			cok_q  <= {out_col_wrap ? 1'b0 : 1'b1, 1'b1, out_col_q != '0};
			fend_q <= out_col_wrap && out_row_wrap;
			acc_q  <= '0;
			wacc_q <= '0;
		end else if (state_q == ST_MAC && rok_q[r_q] && cok_q[c_q]) begin
			acc_q  <= acc_q + nc3f_pkg::SUM_W'(prod);
			wacc_q <= wacc_q + nc3f_pkg::WSUM_W'(wt);
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			quot_q <= div_rsp.quotient;
		end
		if (state_q == ST_FIN && out_free) begin
			out_pix_q  <= clamped;
			out_last_q <= fend_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_pix_q;
	assign m_axis_tlast  = out_last_q;

	// Assertions.
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV) else $error("divider result out of sequence");
	a_center_used: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> (rok_q[1] && cok_q[1])) else $error("center tap masked");
	a_fin_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not delivered to output register");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> out_valid_q) else $error("pending result lost");

endmodule

@@ design/nc3f_line_mem.sv @@
// Line store of the filter: upper and middle line side by side in one word.
// Synchronous memory with one write port and one registered read port; uses nc3f_pkg.
module nc3f_line_mem #(
	parameter int MAX_WIDTH = nc3f_pkg::DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	output logic [15:0]                  rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  logic [15:0]                  wr_data
);

	logic [15:0] mem [MAX_WIDTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/nc3f_divider.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// A zero divisor gives a quotient of zero. Uses nc3f_pkg.
module nc3f_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  nc3f_pkg::div_req_t req,
	output nc3f_pkg::div_rsp_t rsp
);

	localparam int MAG_W = nc3f_pkg::SUM_W - 1;
	localparam int DV_W  = nc3f_pkg::WSUM_W - 1;
	localparam int CNT_W = $clog2(MAG_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] dq_q;
	logic [DV_W:0]    rem_q;
	logic [DV_W-1:0]  dv_q;
	logic             neg_q;
	logic             done_q;

	logic [nc3f_pkg::SUM_W-1:0]  dd_abs;
	logic [nc3f_pkg::WSUM_W-1:0] dv_abs;
	logic [DV_W:0]               trial;
	logic                        fits;

	// Magnitudes of the operands and one restoring step.
	always_comb begin
		dd_abs = req.dividend[nc3f_pkg::SUM_W-1] ? 
			nc3f_pkg::SUM_W'(-req.dividend) : nc3f_pkg::SUM_W'(req.dividend);
		dv_abs = req.divisor[nc3f_pkg::WSUM_W-1] ?
			nc3f_pkg::WSUM_W'(-req.divisor) : nc3f_pkg::WSUM_W'(req.divisor);
		trial  = {rem_q[DV_W-1:0], dq_q[MAG_W-1]};
		fits   = trial >= {1'b0, dv_q};
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= (req.divisor != '0);
				done_q <= (req.divisor == '0);
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient and remainder shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= (req.divisor == '0) ? '0 : dd_abs[MAG_W-1:0];
			rem_q <= '0;
			dv_q  <= dv_abs[DV_W-1:0];
			neg_q <= req.dividend[nc3f_pkg::SUM_W-1] ^ req.divisor[nc3f_pkg::WSUM_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dv_q}) : trial;
			dq_q  <= {dq_q[MAG_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

	// Assertions.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.start) else $error("divider restarted while busy");
	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(req.start && req.divisor == '0) |=> (done_q && dq_q == '0))
		else $error("zero divisor did not give zero");

endmodule
